@@ hdl/ast_pkg.sv @@
// Shared types, codes and defaults for the advection stencil stepper.
// No dependencies; used by every other file under hdl/.
`default_nettype none

package ast_pkg;

    localparam int DEFAULT_MAX_POINTS = 256;
    localparam int SAMPLE_W = 16;

    // command codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // scheme codes
    localparam logic [2:0] SCH_FTCS     = 3'd1;
    localparam logic [2:0] SCH_LAXF     = 3'd2;
    localparam logic [2:0] SCH_LAXW     = 3'd3;
    localparam logic [2:0] SCH_FTBS     = 3'd4;
    localparam logic [2:0] SCH_FTFS     = 3'd5;
    localparam logic [2:0] SCH_LEAPFROG = 3'd6;

    // register indexes
    localparam logic [1:0] CFG_SCHEME    = 2'd0;
    localparam logic [1:0] CFG_RATIO     = 2'd1;
    localparam logic [1:0] CFG_HALF_SQ   = 2'd2;
    localparam logic [1:0] CFG_INTERVALS = 2'd3;

    // register reset values
    localparam logic [2:0]  RST_SCHEME    = SCH_LAXW;
    localparam logic [15:0] RST_RATIO     = 16'd16384;
    localparam logic [15:0] RST_HALF_SQ   = 16'd2048;
    localparam logic [7:0]  RST_INTERVALS = 8'd80;

    // per-beat control from the sequencer, aligned with memory read data
    typedef struct packed {
        logic valid;    // a read slot returns data this cycle
        logic inject;   // use saved point 1 instead of memory data
        logic compute;  // window is complete after this shift
        logic first;    // data is point 1, save it for the wrap
        logic last;     // final window of the step
    } dp_ctl_t;

    // per-point result of the arithmetic pipe
    typedef struct packed {
        logic wr_valid;
        logic last;
        logic clipped;
    } dp_res_t;

endpackage

`default_nettype wire

@@ hdl/ast_grid_store.sv @@
// Two grid memories (current level and previous level), 1R1W each,
// with registered (synchronous) read. Uses ast_pkg.
`default_nettype none

module ast_grid_store #(
    parameter int DEPTH = ast_pkg::DEFAULT_MAX_POINTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                                   clk,
    input  wire                                   now_rd_en,
    input  wire  [AW-1:0]                         now_rd_addr,
    output logic signed [ast_pkg::SAMPLE_W-1:0]   now_rd_data,
    input  wire                                   now_wr_en,
    input  wire  [AW-1:0]                         now_wr_addr,
    input  wire  signed [ast_pkg::SAMPLE_W-1:0]   now_wr_data,
    input  wire                                   prev_rd_en,
    input  wire  [AW-1:0]                         prev_rd_addr,
    output logic signed [ast_pkg::SAMPLE_W-1:0]   prev_rd_data,
    input  wire                                   prev_wr_en,
    input  wire  [AW-1:0]                         prev_wr_addr,
    input  wire  signed [ast_pkg::SAMPLE_W-1:0]   prev_wr_data
);

    logic [ast_pkg::SAMPLE_W-1:0] grid_now_mem  [DEPTH];
    logic [ast_pkg::SAMPLE_W-1:0] grid_prev_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (now_wr_en)
        begin
            grid_now_mem[now_wr_addr] <= now_wr_data;
        end
        if (now_rd_en)
        begin
            now_rd_data <= grid_now_mem[now_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_wr_en)
        begin
            grid_prev_mem[prev_wr_addr] <= prev_wr_data;
        end
        if (prev_rd_en)
        begin
            prev_rd_data <= grid_prev_mem[prev_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ast_datapath.sv @@
// Stencil window and three-stage arithmetic pipe: window shift, operand
// select, multiply, then accumulate/round/clip. Uses ast_pkg types.
`default_nettype none

module ast_datapath (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  ast_pkg::dp_ctl_t                      ctl,
    input  wire  signed [ast_pkg::SAMPLE_W-1:0]   now_data,
    input  wire  signed [ast_pkg::SAMPLE_W-1:0]   prev_data,
    input  wire  [2:0]                            sel,
    input  wire  [15:0]                           ratio,
    input  wire  [15:0]                           half_sq,
    output ast_pkg::dp_res_t                      res,
    output logic signed [ast_pkg::SAMPLE_W-1:0]   new_sample,
    output logic signed [ast_pkg::SAMPLE_W-1:0]   old_sample
);

    // window: c = left, b = center, a = right, p = previous level at center
    logic signed [15:0] a_reg, b_reg, c_reg, p_reg, first_reg;
    logic               w_valid_reg, w_last_reg;

    logic signed [31:0] base_next, s1_base_reg, s2_base_reg;
    logic signed [17:0] d1_next, s1_d1_reg;
    logic signed [18:0] d2_next, s1_d2_reg;
    logic signed [15:0] s1_b_reg, s2_b_reg;
    logic               s1_valid_reg, s1_last_reg, s2_valid_reg, s2_last_reg;
    logic signed [34:0] prod1_next, s2_prod1_reg;
    logic signed [35:0] prod2_next, s2_prod2_reg;

    logic signed [17:0] diff_ac, diff_bc, diff_ab;
    logic signed [18:0] curv;
    logic signed [37:0] acc;
    logic signed [22:0] q;

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            c_reg <= b_reg;
            b_reg <= a_reg;
            a_reg <= ctl.inject ? first_reg : now_data;
            p_reg <= prev_data;
            if (ctl.first)
            begin
                first_reg <= now_data;
            end
        end
    end

    // operand select
    always_comb
    begin
        diff_ac = 18'(a_reg) - 18'(c_reg);
        diff_bc = 18'(b_reg) - 18'(c_reg);
        diff_ab = 18'(a_reg) - 18'(b_reg);
        curv    = 19'(a_reg) + 19'(c_reg) - (19'(b_reg) <<< 1);
        base_next = 32'(b_reg) <<< 15;
        d1_next   = diff_ac;
        d2_next   = '0;
        unique case (sel) inside
            ast_pkg::SCH_FTCS:
            begin
            end
            ast_pkg::SCH_LAXF:
            begin
                base_next = (32'(a_reg) + 32'(c_reg)) <<< 14;
            end
            ast_pkg::SCH_LAXW:
            begin
                d2_next = curv <<< 1;
            end
            ast_pkg::SCH_FTBS:
            begin
                d1_next = diff_bc <<< 1;
            end
            ast_pkg::SCH_FTFS:
            begin
                d1_next = diff_ab <<< 1;
            end
            default:
            begin
                base_next = 32'(p_reg) <<< 15;
                d1_next   = diff_ac <<< 1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s1_base_reg <= base_next;
        s1_d1_reg   <= d1_next;
        s1_d2_reg   <= d2_next;
        s1_b_reg    <= b_reg;
    end

    assign prod1_next = 35'($signed({1'b0, ratio}) * s1_d1_reg);
    assign prod2_next = 36'($signed({1'b0, half_sq}) * s1_d2_reg);

    always_ff @(posedge clk)
    begin
        s2_base_reg  <= s1_base_reg;
        s2_prod1_reg <= prod1_next;
        s2_prod2_reg <= prod2_next;
        s2_b_reg     <= s1_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg  <= 1'b0;
            w_last_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            w_valid_reg  <= ctl.valid & ctl.compute;
            w_last_reg   <= ctl.valid & ctl.last;
            s1_valid_reg <= w_valid_reg;
            s1_last_reg  <= w_last_reg;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // round half up, then clip to 16 bits
    always_comb
    begin
        acc = 38'(s2_base_reg) + 38'(s2_prod1_reg) + 38'(s2_prod2_reg) + 38'sd16384;
        q   = acc[37:15];
        res.wr_valid = s2_valid_reg;
        res.last     = s2_last_reg;
        res.clipped  = 1'b0;
        new_sample   = q[15:0];
        if (q > 23'sd32767)
        begin
            new_sample  = 16'sh7fff;
            res.clipped = 1'b1;
        end
        else if (q < -23'sd32768)
        begin
            new_sample  = 16'sh8000;
            res.clipped = 1'b1;
        end
    end

    assign old_sample = s2_b_reg;

endmodule

`default_nettype wire

@@ hdl/advection_stencil_stepper.sv @@
// Top level of the periodic 1-D advection stepper: command sequencer,
// config registers; instantiates ast_grid_store and ast_datapath (ast_pkg).
`default_nettype none

// Usage
//   Command channel: a beat is taken when start is high and busy is low.
//   func selects write point, advance one time step, or read point. Every
//   command, also an unused code or an out-of-grid access, returns exactly
//   one result beat: done high for one cycle with read_value, step_done and
//   saturated. The receiver cannot stall; results must be taken as shown.
//   Config channel: cfg_ready is always high; a write lands when cfg_valid
//   is high. Write config only while the block is idle.
//   Write or unused code: done in the next cycle, busy stays low. Read: done
//   follows the memory read and the read state. Time step: a read slot per
//   grid point (J = effective interval count), a wrap read of point J-1 and
//   a slot that reuses point 1 feed the arithmetic pipe, and the result
//   register then raises done.
//   Throughput: for a read or a step, busy holds from the accepting edge
//   until the result beat, so the next command can be taken in the cycle
//   that carries done. Reset clears registers to defaults and the history
//   flag; grid memory is undefined until written.
module advection_stencil_stepper #(
    parameter int MAX_POINTS = ast_pkg::DEFAULT_MAX_POINTS
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         func,
    input  wire  [7:0]         point_index,
    input  wire  signed [15:0] point_value,
    output logic               done,
    output logic signed [15:0] read_value,
    output logic               step_done,
    output logic               saturated,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [1:0]         cfg_index,
    input  wire  [15:0]        cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int KW = AW + 1;
    localparam int IW = (AW > 8) ? AW : 8;
    localparam logic [IW-1:0] TOP_POINT = IW'(MAX_POINTS - 1);
    localparam logic [IW-1:0] MIN_J = IW'(2);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    scheme_reg;
    logic [15:0]   ratio_reg, half_sq_reg;
    logic [7:0]    intervals_reg;
    logic [2:0]    sel_reg, sel_next;
    logic          has_prev_reg, sat_reg, in_range_reg;
    logic [KW-1:0] k_reg, km1, km2, jmax_k;
    logic [AW-1:0] wr_addr_reg, jmax;
    logic [IW-1:0] j_ext, jmax_w, idx_ext;
    logic          accept, idx_ok;

    logic          done_reg, step_done_reg, saturated_reg;
    logic signed [15:0] read_value_reg;

    ast_pkg::dp_ctl_t ctl_reg, ctl_next;
    ast_pkg::dp_res_t res;

    logic          now_rd_en, now_wr_en, prev_rd_en;
    logic [AW-1:0] now_rd_addr, now_wr_addr, prev_rd_addr;
    logic signed [15:0] now_rd_data, now_wr_data, prev_rd_data;
    logic signed [15:0] new_sample, old_sample;

    // effective interval count, clamped to the grid memory
    always_comb
    begin
        j_ext = IW'(intervals_reg);
        if (j_ext < MIN_J)
        begin
            jmax_w = MIN_J;
        end
        else if (j_ext > TOP_POINT)
        begin
            jmax_w = TOP_POINT;
        end
        else
        begin
            jmax_w = j_ext;
        end
    end
    assign jmax    = jmax_w[AW-1:0];
    assign jmax_k  = KW'(jmax);
    assign idx_ext = IW'(point_index);
    assign idx_ok  = (idx_ext <= jmax_w);

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg    <= ast_pkg::RST_SCHEME;
            ratio_reg     <= ast_pkg::RST_RATIO;
            half_sq_reg   <= ast_pkg::RST_HALF_SQ;
            intervals_reg <= ast_pkg::RST_INTERVALS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ast_pkg::CFG_SCHEME:    scheme_reg    <= cfg_data[2:0];
                ast_pkg::CFG_RATIO:     ratio_reg     <= cfg_data;
                ast_pkg::CFG_HALF_SQ:   half_sq_reg   <= cfg_data;
                ast_pkg::CFG_INTERVALS: intervals_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Codes 0, 6 and 7 mean leapfrog; without a previous level it runs FTFS.
    always_comb
    begin
        unique case (scheme_reg) inside
            ast_pkg::SCH_FTCS, ast_pkg::SCH_LAXF, ast_pkg::SCH_LAXW,
            ast_pkg::SCH_FTBS, ast_pkg::SCH_FTFS:
                sel_next = scheme_reg;
            default:
                sel_next = has_prev_reg ? ast_pkg::SCH_LEAPFROG : ast_pkg::SCH_FTFS;
        endcase
    end

    // Step read slots: k=0 reads point J-1 (left of point 0), k=1..J+1 read
    // points 0..J, and the final slot reuses the saved point 1 as the right
    // neighbor of point J. The previous level at point k-2 is read along.
    assign km1 = k_reg - KW'(1);
    assign km2 = k_reg - KW'(2);

    always_comb
    begin
        ctl_next.valid   = (state_reg == S_STEP);
        ctl_next.inject  = (k_reg == jmax_k + KW'(2));
        ctl_next.compute = (k_reg >= KW'(2));
        ctl_next.first   = (k_reg == KW'(2));
        ctl_next.last    = (k_reg == jmax_k + KW'(2));

        now_rd_en   = 1'b0;
        now_rd_addr = idx_ext[AW-1:0];
        if (state_reg == S_STEP)
        begin
            now_rd_en   = (k_reg <= jmax_k + KW'(1));
            now_rd_addr = (k_reg == '0) ? (jmax - AW'(1)) : km1[AW-1:0];
        end
        else if (accept && func == ast_pkg::FUNC_READ)
        begin
            now_rd_en = 1'b1;
        end
        prev_rd_en   = (state_reg == S_STEP) && (k_reg >= KW'(2));
        prev_rd_addr = km2[AW-1:0];

        // new level goes into the current grid, the old one shifts back
        now_wr_en   = res.wr_valid | (accept && func == ast_pkg::FUNC_WRITE && idx_ok);
        now_wr_addr = res.wr_valid ? wr_addr_reg : idx_ext[AW-1:0];
        now_wr_data = res.wr_valid ? new_sample : point_value;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && func == ast_pkg::FUNC_READ)
                begin
                    state_next = S_READ;
                end
                else if (accept && func == ast_pkg::FUNC_STEP)
                begin
                    state_next = S_STEP;
                end
            end
            S_READ:
                state_next = S_IDLE;
            S_STEP:
            begin
                if (k_reg == jmax_k + KW'(2))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (res.wr_valid && res.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            wr_addr_reg   <= '0;
            sel_reg       <= ast_pkg::SCH_FTFS;
            has_prev_reg  <= 1'b0;
            sat_reg       <= 1'b0;
            in_range_reg  <= 1'b0;
            ctl_reg       <= '0;
            done_reg      <= 1'b0;
            step_done_reg <= 1'b0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctl_reg       <= ctl_next;
            done_reg      <= 1'b0;
            step_done_reg <= 1'b0;
            saturated_reg <= 1'b0;

            if (state_reg == S_STEP)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (res.wr_valid)
            begin
                wr_addr_reg <= wr_addr_reg + AW'(1);
                sat_reg     <= sat_reg | res.clipped;
            end

            if (accept)
            begin
                unique case (func)
                    ast_pkg::FUNC_WRITE:
                    begin
                        done_reg <= 1'b1;
                        if (idx_ok)
                        begin
                            has_prev_reg <= 1'b0;
                        end
                    end
                    ast_pkg::FUNC_STEP:
                    begin
                        sel_reg      <= sel_next;
                        has_prev_reg <= 1'b1;
                        sat_reg      <= 1'b0;
                        k_reg        <= '0;
                        wr_addr_reg  <= '0;
                    end
                    ast_pkg::FUNC_READ:
                        in_range_reg <= idx_ok;
                    default:
                        done_reg <= 1'b1;
                endcase
            end

            if (state_reg == S_READ)
            begin
                done_reg <= 1'b1;
            end
            if (state_reg == S_DRAIN && res.wr_valid && res.last)
            begin
                done_reg      <= 1'b1;
                step_done_reg <= 1'b1;
                saturated_reg <= sat_reg | res.clipped;
            end
        end
    end

    // read data is payload; it holds zero unless a read lands in the grid
    always_ff @(posedge clk)
    begin
        read_value_reg <= (state_reg == S_READ && in_range_reg) ? now_rd_data : '0;
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign step_done  = step_done_reg;
    assign saturated  = saturated_reg;

    ast_grid_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .clk          (clk),
        .now_rd_en    (now_rd_en),
        .now_rd_addr  (now_rd_addr),
        .now_rd_data  (now_rd_data),
        .now_wr_en    (now_wr_en),
        .now_wr_addr  (now_wr_addr),
        .now_wr_data  (now_wr_data),
        .prev_rd_en   (prev_rd_en),
        .prev_rd_addr (prev_rd_addr),
        .prev_rd_data (prev_rd_data),
        .prev_wr_en   (res.wr_valid),
        .prev_wr_addr (wr_addr_reg),
        .prev_wr_data (old_sample)
    );

    ast_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_reg),
        .now_data   (now_rd_data),
        .prev_data  (prev_rd_data),
        .sel        (sel_reg),
        .ratio      (ratio_reg),
        .half_sq    (half_sq_reg),
        .res        (res),
        .new_sample (new_sample),
        .old_sample (old_sample)
    );

    // the last point written by a step is point J
    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res.wr_valid && res.last |-> wr_addr_reg == jmax)
        else $error("step finished at wrong point");

    // pipe writes happen only while a step is in flight
    a_wr_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.wr_valid |-> (state_reg == S_STEP || state_reg == S_DRAIN))
        else $error("grid write outside a step");

    // a step result follows the drain
    a_step_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        step_done |-> $past(state_reg) == S_DRAIN)
        else $error("step_done without a finished step");

    // step and read results never mix
    a_fields_apart: assert property (@(posedge clk) disable iff (!rst_n)
        done && step_done |-> read_value == 16'sd0)
        else $error("read data on a step result");

    // a grid write in the same cycle as a read stays behind the read address
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        res.wr_valid && now_rd_en |-> wr_addr_reg < now_rd_addr)
        else $error("write overtook the read sweep");

endmodule

`default_nettype wire
